// File: hw/rtl/motor_ramp_drive_controller_macros.svh
// assertion macros shared by the motor ramp drive controller rtl
// the including module must provide clk_i and rst_ni
`ifndef MOTOR_RAMP_DRIVE_CONTROLLER_MACROS_SVH
`define MOTOR_RAMP_DRIVE_CONTROLLER_MACROS_SVH

// checked on every clock edge outside reset
`define MRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define MRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/mrd_pkg.sv
// shared types, codes and helpers for the motor ramp drive controller
// no dependencies
`default_nettype none

package mrd_pkg;

  localparam int unsigned SpeedW     = 12;
  localparam int unsigned StepW      = 11;
  localparam int unsigned PwmBitsDef = 11;
  localparam int unsigned DataW      = 32;
  localparam int unsigned AddrW      = 4;

  localparam logic [StepW-1:0] RiseReset  = 11'd300;
  localparam logic [StepW-1:0] FallReset  = 11'd300;
  localparam logic [StepW-1:0] LimitReset = 11'd2047;

  typedef enum logic [3:0] {
    REQ_TICK      = 4'd0,
    REQ_SET_SPEED = 4'd1,
    REQ_SENSOR    = 4'd2,
    REQ_STOP      = 4'd3,
    REQ_DISABLE   = 4'd4,
    REQ_ENABLE    = 4'd5,
    REQ_BRAKE_ON  = 4'd6,
    REQ_BRAKE_OFF = 4'd7,
    REQ_EMG_STOP  = 4'd8,
    REQ_EMG_RESET = 4'd9,
    REQ_IDLE      = 4'd10
  } req_e;

  typedef enum logic [1:0] {
    REG_RISE  = 2'd0,
    REG_FALL  = 2'd1,
    REG_LIMIT = 2'd2
  } reg_e;

  typedef logic signed [SpeedW-1:0] speed_t;

  typedef struct packed {
    req_e   req;
    speed_t blade;
    speed_t left;
    speed_t right;
    logic   sensor;
  } item_t;

  typedef struct packed {
    logic [StepW-1:0] rise;
    logic [StepW-1:0] fall;
    logic [StepW-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic left_fwd;
    logic right_fwd;
    logic left_brake;
    logic right_brake;
    logic blade_brake;
    logic power;
    logic emg;
    logic blocked;
  } pins_t;

  // one ramp step toward the goal, never past it
  function automatic speed_t ramp(speed_t cur, speed_t goal,
                                  logic [StepW-1:0] rise, logic [StepW-1:0] fall);
    logic signed [SpeedW+1:0] c;
    logic signed [SpeedW+1:0] g;
    logic signed [SpeedW+1:0] up;
    logic signed [SpeedW+1:0] dn;
    speed_t r;
    c  = (SpeedW+2)'(cur);
    g  = (SpeedW+2)'(goal);
    up = c + $signed({3'b000, rise});
    dn = c - $signed({3'b000, fall});
    if (c < g) begin
      r = (up > g) ? goal : speed_t'(up);
    end else if (c > g) begin
      r = (dn < g) ? goal : speed_t'(dn);
    end else begin
      r = cur;
    end
    return r;
  endfunction

  // magnitude of a signed speed, full scale gives 2048
  function automatic logic [SpeedW-1:0] magnitude(speed_t s);
    return s[SpeedW-1] ? (~s + 12'd1) : s;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mrd_cfg.sv
// register file for step sizes and pwm limit, apb-style access
// depends on mrd_pkg
`default_nettype none

module mrd_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mrd_pkg::AddrW-1:0]    paddr,
  input  wire logic [mrd_pkg::DataW-1:0]    pwdata,
  output logic      [mrd_pkg::DataW-1:0]    prdata,
  output logic                              pready,
  output mrd_pkg::cfg_t                     cfg_o
);

  mrd_pkg::cfg_t cfg_q;
  mrd_pkg::cfg_t cfg_d;
  mrd_pkg::reg_e idx;
  logic          wr_en;

  assign pready = 1'b1;
  assign idx    = mrd_pkg::reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        mrd_pkg::REG_RISE:  cfg_d.rise  = pwdata[mrd_pkg::StepW-1:0];
        mrd_pkg::REG_FALL:  cfg_d.fall  = pwdata[mrd_pkg::StepW-1:0];
        mrd_pkg::REG_LIMIT: cfg_d.limit = pwdata[mrd_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mrd_pkg::REG_RISE:  prdata = mrd_pkg::DataW'(cfg_q.rise);
      mrd_pkg::REG_FALL:  prdata = mrd_pkg::DataW'(cfg_q.fall);
      mrd_pkg::REG_LIMIT: prdata = mrd_pkg::DataW'(cfg_q.limit);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rise  <= mrd_pkg::RiseReset;
      cfg_q.fall  <= mrd_pkg::FallReset;
      cfg_q.limit <= mrd_pkg::LimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/mrd_core.sv
// speed state, ramp logic and pin decode; the state registers are the result
// depends on mrd_pkg and the shared assertion macros
`default_nettype none
`include "motor_ramp_drive_controller_macros.svh"

module mrd_core #(
  parameter int unsigned PWM_BITS = mrd_pkg::PwmBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire mrd_pkg::item_t      item_i,
  input  wire mrd_pkg::cfg_t       cfg_i,
  output logic [PWM_BITS-1:0]      pwm_blade_o,
  output logic [PWM_BITS-1:0]      pwm_left_o,
  output logic [PWM_BITS-1:0]      pwm_right_o,
  output mrd_pkg::pins_t           pins_o
);

  localparam logic [16:0] PwmMax = 17'((1 << PWM_BITS) - 1);

  mrd_pkg::speed_t goal_q [3];
  mrd_pkg::speed_t goal_d [3];
  mrd_pkg::speed_t now_q  [3];
  mrd_pkg::speed_t now_d  [3];
  mrd_pkg::speed_t now_r  [3];
  logic [PWM_BITS-1:0] pwm_q [3];
  logic [PWM_BITS-1:0] pwm_d [3];
  logic [1:0] dir_q, dir_d;
  logic [2:0] brake_q, brake_d;
  logic       supply_q, supply_d;
  logic       emg_q, emg_d;
  logic       block_q, block_d;

  function automatic logic [PWM_BITS-1:0] clamp(logic [mrd_pkg::SpeedW-1:0] mag,
                                                logic [mrd_pkg::StepW-1:0] limit);
    logic [mrd_pkg::SpeedW-1:0] m;
    logic [16:0]                w;
    m = (mag > {1'b0, limit}) ? {1'b0, limit} : mag;
    w = (17'(m) > PwmMax) ? PwmMax : 17'(m);
    return PWM_BITS'(w);
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      now_r[i] = mrd_pkg::ramp(now_q[i], goal_q[i], cfg_i.rise, cfg_i.fall);
    end
  end

  always_comb begin
    mrd_pkg::speed_t lt;
    mrd_pkg::speed_t rt;
    logic            stop_all;
    goal_d   = goal_q;
    now_d    = now_q;
    pwm_d    = pwm_q;
    dir_d    = dir_q;
    brake_d  = brake_q;
    supply_d = supply_q;
    emg_d    = emg_q;
    block_d  = block_q;
    stop_all = 1'b0;
    lt       = item_i.left;
    rt       = item_i.right;
    unique case (item_i.req)
      mrd_pkg::REQ_TICK: begin
        now_d    = now_r;
        // blade never reverses, a negative speed drives zero
        pwm_d[0] = clamp(now_r[0][mrd_pkg::SpeedW-1] ? '0 : now_r[0], cfg_i.limit);
        pwm_d[1] = clamp(mrd_pkg::magnitude(now_r[1]), cfg_i.limit);
        pwm_d[2] = clamp(mrd_pkg::magnitude(now_r[2]), cfg_i.limit);
        // right wheel is wired inverted
        dir_d    = {now_r[2] < 0, now_r[1] >= 0};
        brake_d  = {brake_q[2], now_r[2] != 0, now_r[1] != 0};
      end
      mrd_pkg::REQ_SET_SPEED: begin
        if (block_q) begin
          if (lt > 0) lt = '0;
          if (rt > 0) rt = '0;
          if (lt < 0 || rt < 0) block_d = 1'b0;
        end
        goal_d[0] = item_i.blade;
        goal_d[1] = lt;
        goal_d[2] = rt;
      end
      mrd_pkg::REQ_SENSOR: begin
        if (item_i.sensor) block_d = 1'b1;
      end
      mrd_pkg::REQ_STOP: stop_all = 1'b1;
      mrd_pkg::REQ_DISABLE: begin
        stop_all = 1'b1;
        supply_d = 1'b0;
        brake_d  = 3'b111;
      end
      mrd_pkg::REQ_ENABLE: begin
        supply_d = 1'b1;
        brake_d  = 3'b111;
      end
      mrd_pkg::REQ_BRAKE_ON:  brake_d = 3'b000;
      mrd_pkg::REQ_BRAKE_OFF: brake_d = 3'b111;
      mrd_pkg::REQ_EMG_STOP: begin
        stop_all = 1'b1;
        brake_d  = 3'b000;
        emg_d    = 1'b1;
        supply_d = 1'b0;
      end
      mrd_pkg::REQ_EMG_RESET: begin
        emg_d    = 1'b0;
        supply_d = 1'b0;
        brake_d  = 3'b111;
      end
      mrd_pkg::REQ_IDLE: supply_d = 1'b0;
      default: ;
    endcase
    if (stop_all) begin
      for (int i = 0; i < 3; i++) begin
        goal_d[i] = '0;
        now_d[i]  = '0;
        pwm_d[i]  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        goal_q[i] <= '0;
        now_q[i]  <= '0;
        pwm_q[i]  <= '0;
      end
      dir_q    <= '0;
      brake_q  <= '0;
      supply_q <= 1'b0;
      emg_q    <= 1'b0;
      block_q  <= 1'b0;
    end else if (fire_i) begin
      goal_q   <= goal_d;
      now_q    <= now_d;
      pwm_q    <= pwm_d;
      dir_q    <= dir_d;
      brake_q  <= brake_d;
      supply_q <= supply_d;
      emg_q    <= emg_d;
      block_q  <= block_d;
    end
  end

  assign pwm_blade_o        = pwm_q[0];
  assign pwm_left_o         = pwm_q[1];
  assign pwm_right_o        = pwm_q[2];
  assign pins_o.left_fwd    = dir_q[0];
  assign pins_o.right_fwd   = dir_q[1];
  assign pins_o.left_brake  = brake_q[0];
  assign pins_o.right_brake = brake_q[1];
  assign pins_o.blade_brake = brake_q[2];
  assign pins_o.power       = supply_q;
  assign pins_o.emg         = emg_q;
  assign pins_o.blocked     = block_q;

  `MRD_ASSERT(a_emg_stops_all, (fire_i && item_i.req == mrd_pkg::REQ_EMG_STOP |=> emg_q && !supply_q && pwm_q[1] == '0 && pwm_q[2] == '0 && now_q[0] == '0), "emergency stop left motion or power")
  `MRD_ASSERT(a_hold_without_request, (!fire_i |=> $stable(now_q[1]) && $stable(goal_q[1]) && $stable(brake_q)), "state moved without a request")
  `MRD_ASSERT(a_tick_brake_follows_speed, (fire_i && item_i.req == mrd_pkg::REQ_TICK |=> brake_q[0] == (now_q[1] != 0) && brake_q[1] == (now_q[2] != 0)), "wheel brake disagrees with speed after tick")

endmodule

`default_nettype wire

// File: hw/rtl/motor_ramp_drive_controller.sv
// pipeline: two register stages, the request register, then the state register that doubles
// as the result; throughput: one request per cycle while the output is not stalled,
// set by the single state update per cycle
// reset: speeds, goals, pwm and pins cleared, steps 300, pwm limit 2047
// depends on mrd_pkg, mrd_cfg, mrd_core and the shared assertion macros
`default_nettype none
`include "motor_ramp_drive_controller_macros.svh"

module motor_ramp_drive_controller #(
  parameter int unsigned PWM_BITS = mrd_pkg::PwmBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mrd_pkg::AddrW-1:0]    paddr,
  input  wire logic [mrd_pkg::DataW-1:0]    pwdata,
  output logic      [mrd_pkg::DataW-1:0]    prdata,
  output logic                              pready,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [3:0]                   req_type_i,
  input  wire logic signed [11:0]           blade_target_i,
  input  wire logic signed [11:0]           left_target_i,
  input  wire logic signed [11:0]           right_target_i,
  input  wire logic                         sensor_block_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [PWM_BITS-1:0]               pwm_blade_o,
  output logic [PWM_BITS-1:0]               pwm_left_o,
  output logic [PWM_BITS-1:0]               pwm_right_o,
  output logic                              left_forward_pin_o,
  output logic                              right_forward_pin_o,
  output logic                              left_brake_pin_o,
  output logic                              right_brake_pin_o,
  output logic                              blade_brake_pin_o,
  output logic                              power_enable_o,
  output logic                              emergency_active_o,
  output logic                              forward_blocked_o
);

  mrd_pkg::cfg_t  cfg;
  mrd_pkg::pins_t pins;
  mrd_pkg::item_t item_q, item_d;
  logic           in_valid_q, in_valid_d;
  logic           out_valid_q, out_valid_d;
  logic           fire;
  logic           accept;

  mrd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // a held request moves on once the result slot is free or being taken
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    item_d.req    = mrd_pkg::req_e'(req_type_i);
    item_d.blade  = blade_target_i;
    item_d.left   = left_target_i;
    item_d.right  = right_target_i;
    item_d.sensor = sensor_block_i;
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  mrd_core #(
    .PWM_BITS (PWM_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (item_q),
    .cfg_i       (cfg),
    .pwm_blade_o (pwm_blade_o),
    .pwm_left_o  (pwm_left_o),
    .pwm_right_o (pwm_right_o),
    .pins_o      (pins)
  );

  assign out_valid_o         = out_valid_q;
  assign left_forward_pin_o  = pins.left_fwd;
  assign right_forward_pin_o = pins.right_fwd;
  assign left_brake_pin_o    = pins.left_brake;
  assign right_brake_pin_o   = pins.right_brake;
  assign blade_brake_pin_o   = pins.blade_brake;
  assign power_enable_o      = pins.power;
  assign emergency_active_o  = pins.emg;
  assign forward_blocked_o   = pins.blocked;

  `MRD_ASSERT(a_accept_fills_slot, (accept |=> in_valid_q), "accepted request was not held")

endmodule

`default_nettype wire

// File: dv/tb_motor_ramp_drive_controller.sv
// self-checking testbench for motor_ramp_drive_controller: predicts ramps, pwm and pins
// per request with a scoreboard class, drives the input handshake and the apb port from tasks and
// the output stall from its own process; depends on mrd_pkg and the motor_ramp_drive_controller rtl
`timescale 1ns / 100ps

typedef struct packed {
  logic [10:0] pwm_blade;
  logic [10:0] pwm_left;
  logic [10:0] pwm_right;
  logic        left_fwd;
  logic        right_fwd;
  logic        left_brake;
  logic        right_brake;
  logic        blade_brake;
  logic        power;
  logic        emg;
  logic        blocked;
} drive_out_t;

localparam logic [3:0] REQ_UNUSED_LO = 4'd11;
localparam logic [3:0] REQ_UNUSED_HI = 4'd15;

class drive_scoreboard;
  int          goal_spd[3];   // 0 blade, 1 left, 2 right
  int          cur_spd[3];
  logic [10:0] pwm_q[3];
  logic        left_fwd;
  logic        right_fwd;
  logic [2:0]  brakes;        // bit0 left, bit1 right, bit2 blade; 0 applies
  logic        supply;
  logic        emg;
  logic        blocked;
  int          rise;
  int          fall;
  int          limit;
  drive_out_t  expected_drive[$];
  int          errors;

  function new();
    halt_all();
    left_fwd  = 1'b0;
    right_fwd = 1'b0;
    brakes    = 3'b000;
    supply    = 1'b0;
    emg       = 1'b0;
    blocked   = 1'b0;
    rise      = mrd_pkg::RiseReset;
    fall      = mrd_pkg::FallReset;
    limit     = mrd_pkg::LimitReset;
    errors    = 0;
  endfunction

  function void halt_all();
    for (int i = 0; i < 3; i++) begin
      goal_spd[i] = 0;
      cur_spd[i]  = 0;
      pwm_q[i]    = '0;
    end
  endfunction

  function void set_reg(mrd_pkg::reg_e idx, logic [10:0] v);
    case (idx)
      mrd_pkg::REG_RISE:  rise  = v;
      mrd_pkg::REG_FALL:  fall  = v;
      mrd_pkg::REG_LIMIT: limit = v;
      default: ;
    endcase
  endfunction

  function int ramp_toward(int cur, int goal);
    if (cur < goal) begin
      cur = cur + rise;
      if (cur > goal) cur = goal;
    end else if (cur > goal) begin
      cur = cur - fall;
      if (cur < goal) cur = goal;
    end
    return cur;
  endfunction

  function logic [10:0] clamp_pwm(int mag);
    if (mag < 0) mag = 0;
    if (mag > limit) mag = limit;
    return mag[10:0];
  endfunction

  function drive_out_t step_drive(logic [3:0] code, mrd_pkg::speed_t b,
                                  mrd_pkg::speed_t l, mrd_pkg::speed_t r, logic s);
    int lt;
    int rt;
    int lmag;
    int rmag;
    drive_out_t d;
    lt = l;
    rt = r;
    case (code)
      mrd_pkg::REQ_TICK: begin
        for (int i = 0; i < 3; i++) cur_spd[i] = ramp_toward(cur_spd[i], goal_spd[i]);
        lmag = (cur_spd[1] < 0) ? -cur_spd[1] : cur_spd[1];
        rmag = (cur_spd[2] < 0) ? -cur_spd[2] : cur_spd[2];
        pwm_q[0] = clamp_pwm(cur_spd[0]);
        pwm_q[1] = clamp_pwm(lmag);
        pwm_q[2] = clamp_pwm(rmag);
        left_fwd  = (cur_spd[1] >= 0);
        right_fwd = (cur_spd[2] < 0);
        // blade brake is left alone by a tick
        brakes[0] = (cur_spd[1] != 0);
        brakes[1] = (cur_spd[2] != 0);
      end
      mrd_pkg::REQ_SET_SPEED: begin
        if (blocked) begin
          if (lt > 0) lt = 0;
          if (rt > 0) rt = 0;
          if (lt < 0 || rt < 0) blocked = 1'b0;
        end
        goal_spd[0] = b;
        goal_spd[1] = lt;
        goal_spd[2] = rt;
      end
      mrd_pkg::REQ_SENSOR: if (s) blocked = 1'b1;
      mrd_pkg::REQ_STOP: halt_all();
      mrd_pkg::REQ_DISABLE: begin
        halt_all();
        supply = 1'b0;
        brakes = 3'b111;
      end
      mrd_pkg::REQ_ENABLE: begin
        supply = 1'b1;
        brakes = 3'b111;
      end
      mrd_pkg::REQ_BRAKE_ON:  brakes = 3'b000;
      mrd_pkg::REQ_BRAKE_OFF: brakes = 3'b111;
      mrd_pkg::REQ_EMG_STOP: begin
        halt_all();
        brakes = 3'b000;
        emg    = 1'b1;
        supply = 1'b0;
      end
      mrd_pkg::REQ_EMG_RESET: begin
        emg    = 1'b0;
        supply = 1'b0;
        brakes = 3'b111;
      end
      mrd_pkg::REQ_IDLE: supply = 1'b0;
      default: ;
    endcase
    d.pwm_blade   = pwm_q[0];
    d.pwm_left    = pwm_q[1];
    d.pwm_right   = pwm_q[2];
    d.left_fwd    = left_fwd;
    d.right_fwd   = right_fwd;
    d.left_brake  = brakes[0];
    d.right_brake = brakes[1];
    d.blade_brake = brakes[2];
    d.power       = supply;
    d.emg         = emg;
    d.blocked     = blocked;
    return d;
  endfunction

  function void log_request(logic [3:0] code, mrd_pkg::speed_t b, mrd_pkg::speed_t l,
                            mrd_pkg::speed_t r, logic s);
    expected_drive.push_back(step_drive(code, b, l, r, s));
  endfunction

  function void compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_drive(drive_out_t got);
    drive_out_t want;
    if (expected_drive.size() == 0) begin
      $display("%0t result with none waiting: expected nothing actual %h", $time, got);
      errors++;
      return;
    end
    want = expected_drive.pop_front();
    compare_field("pwm_blade", want.pwm_blade, got.pwm_blade);
    compare_field("pwm_left", want.pwm_left, got.pwm_left);
    compare_field("pwm_right", want.pwm_right, got.pwm_right);
    compare_field("left_forward_pin", want.left_fwd, got.left_fwd);
    compare_field("right_forward_pin", want.right_fwd, got.right_fwd);
    compare_field("left_brake_pin", want.left_brake, got.left_brake);
    compare_field("right_brake_pin", want.right_brake, got.right_brake);
    compare_field("blade_brake_pin", want.blade_brake, got.blade_brake);
    compare_field("power_enable", want.power, got.power);
    compare_field("emergency_active", want.emg, got.emg);
    compare_field("forward_blocked", want.blocked, got.blocked);
  endfunction
endclass

module tb_motor_ramp_drive_controller;

  localparam mrd_pkg::speed_t FULL_REV = mrd_pkg::speed_t'(12'h800);

  logic                       clk_i;
  logic                       rst_ni;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [mrd_pkg::AddrW-1:0]  paddr;
  logic [mrd_pkg::DataW-1:0]  pwdata;
  logic [mrd_pkg::DataW-1:0]  prdata;
  logic                       pready;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [3:0]                 req_type_i;
  mrd_pkg::speed_t            blade_target_i;
  mrd_pkg::speed_t            left_target_i;
  mrd_pkg::speed_t            right_target_i;
  logic                       sensor_block_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [10:0]                pwm_blade_o;
  logic [10:0]                pwm_left_o;
  logic [10:0]                pwm_right_o;
  logic                       left_forward_pin_o;
  logic                       right_forward_pin_o;
  logic                       left_brake_pin_o;
  logic                       right_brake_pin_o;
  logic                       blade_brake_pin_o;
  logic                       power_enable_o;
  logic                       emergency_active_o;
  logic                       forward_blocked_o;

  drive_scoreboard sb;
  int              results_seen = 0;
  logic            send_quiet;

  motor_ramp_drive_controller dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .blade_target_i     (blade_target_i),
    .left_target_i      (left_target_i),
    .right_target_i     (right_target_i),
    .sensor_block_i     (sensor_block_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .pwm_blade_o        (pwm_blade_o),
    .pwm_left_o         (pwm_left_o),
    .pwm_right_o        (pwm_right_o),
    .left_forward_pin_o (left_forward_pin_o),
    .right_forward_pin_o(right_forward_pin_o),
    .left_brake_pin_o   (left_brake_pin_o),
    .right_brake_pin_o  (right_brake_pin_o),
    .blade_brake_pin_o  (blade_brake_pin_o),
    .power_enable_o     (power_enable_o),
    .emergency_active_o (emergency_active_o),
    .forward_blocked_o  (forward_blocked_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_drive(drive_out_t'({pwm_blade_o, pwm_left_o, pwm_right_o,
                                   left_forward_pin_o, right_forward_pin_o,
                                   left_brake_pin_o, right_brake_pin_o, blade_brake_pin_o,
                                   power_enable_o, emergency_active_o,
                                   forward_blocked_o}));
      results_seen++;
    end
  end

  // a fresh stall length after every result, with stall-free stretches
  initial begin : stall_gen
    int   hold;
    int   seen;
    int   stretch;
    logic quiet;
    hold        = 0;
    seen        = 0;
    stretch     = 0;
    quiet       = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (results_seen != seen) begin
        seen = results_seen;
        if (stretch == 0) begin
          quiet   = ($urandom_range(0, 3) == 0);
          stretch = 80;
        end
        stretch--;
        hold = quiet ? 0 : $urandom_range(0, 15);
      end
      out_stall_i <= (hold != 0);
      if (hold != 0) hold--;
    end
  end

  // called and returns at a falling edge
  task automatic send_req(logic [3:0] code, mrd_pkg::speed_t b, mrd_pkg::speed_t l,
                          mrd_pkg::speed_t r, logic s);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= code;
    blade_target_i <= b;
    left_target_i  <= l;
    right_target_i <= r;
    sensor_block_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    sb.log_request(code, b, l, r, s);
    @(negedge clk_i);
  endtask

  task automatic send_cmd(logic [3:0] code);
    send_req(code, mrd_pkg::speed_t'($urandom), mrd_pkg::speed_t'($urandom),
             mrd_pkg::speed_t'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_drive.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(mrd_pkg::reg_e idx, logic [10:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {21'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic mrd_pkg::speed_t pick_speed();
    case ($urandom_range(0, 9))
      0: return FULL_REV;
      1: return mrd_pkg::speed_t'(2047);
      2: return mrd_pkg::speed_t'(-2047);
      3: return mrd_pkg::speed_t'(0);
      4, 5, 6: return mrd_pkg::speed_t'(int'($urandom_range(0, 600)) - 300);
      default: return mrd_pkg::speed_t'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] pick_req();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return mrd_pkg::REQ_TICK;
    if (k < 60) return mrd_pkg::REQ_SET_SPEED;
    if (k < 68) return mrd_pkg::REQ_SENSOR;
    if (k < 70) return mrd_pkg::REQ_STOP;
    if (k < 72) return mrd_pkg::REQ_DISABLE;
    if (k < 78) return mrd_pkg::REQ_ENABLE;
    if (k < 81) return mrd_pkg::REQ_BRAKE_ON;
    if (k < 84) return mrd_pkg::REQ_BRAKE_OFF;
    if (k < 86) return mrd_pkg::REQ_EMG_STOP;
    if (k < 89) return mrd_pkg::REQ_EMG_RESET;
    if (k < 91) return mrd_pkg::REQ_IDLE;
    if (k < 94) return 4'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    return mrd_pkg::REQ_TICK;
  endfunction

  task automatic run_directed();
    send_cmd(mrd_pkg::REQ_TICK);
    send_cmd(mrd_pkg::REQ_ENABLE);
    // full reverse on the right wheel, negative blade
    send_req(mrd_pkg::REQ_SET_SPEED, mrd_pkg::speed_t'(-2047), mrd_pkg::speed_t'(2047),
             FULL_REV, 1'b0);
    repeat (7) send_cmd(mrd_pkg::REQ_TICK);
    send_req(mrd_pkg::REQ_SENSOR, mrd_pkg::speed_t'(0), mrd_pkg::speed_t'(0),
             mrd_pkg::speed_t'(0), 1'b0);
    send_req(mrd_pkg::REQ_SENSOR, mrd_pkg::speed_t'(0), mrd_pkg::speed_t'(0),
             mrd_pkg::speed_t'(0), 1'b1);
    // forward goals are zeroed while blocked, a reverse goal unblocks
    send_req(mrd_pkg::REQ_SET_SPEED, mrd_pkg::speed_t'(500), mrd_pkg::speed_t'(100),
             mrd_pkg::speed_t'(200), 1'b0);
    send_req(mrd_pkg::REQ_SET_SPEED, mrd_pkg::speed_t'(0), mrd_pkg::speed_t'(-5),
             mrd_pkg::speed_t'(3), 1'b0);
    send_cmd(mrd_pkg::REQ_TICK);
    send_cmd(mrd_pkg::REQ_STOP);
    send_cmd(REQ_UNUSED_LO);
    send_cmd(REQ_UNUSED_HI);
    send_cmd(mrd_pkg::REQ_BRAKE_ON);
    send_cmd(mrd_pkg::REQ_BRAKE_OFF);
    send_cmd(mrd_pkg::REQ_DISABLE);
    send_cmd(mrd_pkg::REQ_EMG_STOP);
    send_cmd(mrd_pkg::REQ_EMG_RESET);
    send_cmd(mrd_pkg::REQ_IDLE);
    send_cmd(mrd_pkg::REQ_TICK);
  endtask

  task automatic run_random(int n);
    int         counted;
    int         sent;
    logic [3:0] code;
    counted = 0;
    sent    = 0;
    while (counted < n) begin
      if (sent % 50 == 0) send_quiet = ($urandom_range(0, 3) == 0);
      code = pick_req();
      if (code == mrd_pkg::REQ_SET_SPEED) begin
        send_req(code, pick_speed(), pick_speed(), pick_speed(), 1'($urandom_range(0, 1)));
      end else begin
        send_cmd(code);
      end
      sent++;
      if (code <= mrd_pkg::REQ_IDLE) counted++;
      // hold off the sender until the pipe is empty now and then
      if ($urandom_range(0, 149) == 0) wait_drained();
    end
  endtask

  task automatic apply_phase(int p);
    logic [10:0] r;
    logic [10:0] f;
    logic [10:0] l;
    case (p)
      0: begin r = 11'd1;    f = 11'd1;    l = 11'd2047; end
      1: begin r = 11'd2047; f = 11'd2047; l = 11'd2047; end
      2: begin r = 11'd0;    f = 11'd7;    l = 11'd1000; end
      3: begin r = 11'd5;    f = 11'd0;    l = 11'd0;    end
      4: begin
        r = 11'($urandom_range(1, 2047));
        f = 11'($urandom_range(1, 2047));
        l = 11'($urandom);
      end
      default: begin r = 11'd300; f = 11'd300; l = 11'd1; end
    endcase
    write_reg(mrd_pkg::REG_RISE, r);
    write_reg(mrd_pkg::REG_FALL, f);
    write_reg(mrd_pkg::REG_LIMIT, l);
  endtask

  initial begin
    sb             = new();
    send_quiet     = 1'b0;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    req_type_i     = mrd_pkg::REQ_TICK;
    blade_target_i = '0;
    left_target_i  = '0;
    right_target_i = '0;
    sensor_block_i = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    run_random(100);
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      apply_phase(p);
      run_random(180);
    end
    wait_drained();
    repeat (6) @(posedge clk_i);

    if (sb.errors == 0 && sb.expected_drive.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
